// ===== hw/rtl/checksummed_frame_receiver_unit_macros.svh =====
// Assertion helpers for the frame receiver checkers.
`ifndef CHECKSUMMED_FRAME_RECEIVER_UNIT_MACROS_SVH
`define CHECKSUMMED_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cfr_pkg.sv =====
package cfr_pkg;

    localparam int FRAME_LENGTH = 16;   // 3 .. 64

    localparam int POS_W      = 6;
    localparam int IDLE_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [POS_W-1:0]  LAST_POS = POS_W'(FRAME_LENGTH - 1);
    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE = CFG_IDX_W'(1);

    localparam logic [IDLE_W-1:0] GAP_LIMIT_RST    = IDLE_W'(1000);
    localparam logic [7:0]        HEADER_VALUE_RST = 8'hAA;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic             byte_valid;
        logic [POS_W-1:0] byte_index;
        logic [7:0]       byte_data;
        logic             frame_end;
        logic             frame_good;
        logic             receive_done;
    } out_item_t;

    typedef struct packed {
        logic [IDLE_W-1:0] gap_limit;
        logic [7:0]        header_value;
    } cfg_t;

endpackage

// ===== hw/rtl/cfr_cfg_regs.sv =====
module cfr_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cfr_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output cfr_pkg::cfg_t                 cfg
);
    import cfr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GAP_LIMIT:    cfg_next.gap_limit    = cfg_wr_data[IDLE_W-1:0];
                CFG_HEADER_VALUE: cfg_next.header_value = cfg_wr_data[7:0];
                default:          cfg_next = cfg_reg;   // unmapped index
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gap_limit    <= GAP_LIMIT_RST;
            cfg_reg.header_value <= HEADER_VALUE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/cfr_in_reg.sv =====
module cfr_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cfr_pkg::in_item_t s_data,
    output logic              item_valid,
    output cfr_pkg::in_item_t item,
    input  logic              item_take
);
    import cfr_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // free, or emptying this cycle
    assign s_ready = !valid_reg || item_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hw/rtl/cfr_frame_core.sv =====
module cfr_frame_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfr_pkg::cfg_t      cfg,
    input  logic               item_valid,
    input  cfr_pkg::in_item_t  item,
    output logic               item_take,
    output logic               m_valid,
    input  logic               m_ready,
    output cfr_pkg::out_item_t m_data
);
    import cfr_pkg::*;

    logic [POS_W-1:0]  count_reg, count_next;
    logic [7:0]        sum_reg, sum_next;
    logic              hdr_ok_reg, hdr_ok_next;
    logic [IDLE_W-1:0] idle_reg, idle_next;
    logic              done_reg, done_next;
    logic              out_valid_reg;
    out_item_t         out_reg, out_next;

    logic             gap;
    logic [POS_W-1:0] cnt;
    logic [POS_W-1:0] pos;
    logic             done_pre;
    logic [7:0]       sum_base;
    logic [7:0]       weighted;
    logic             is_last;
    logic             good;

    assign item_take = item_valid && (!out_valid_reg || m_ready);

    always_comb begin
        gap      = idle_reg > cfg.gap_limit;
        cnt      = gap ? '0 : count_reg;
        pos      = ({1'b0, cnt} >= (POS_W + 1)'(FRAME_LENGTH)) ? '0 : cnt;
        done_pre = gap ? 1'b0 : done_reg;
        is_last  = (pos == LAST_POS);
        sum_base = (pos == '0) ? 8'd0 : sum_reg;
        weighted = 8'(16'(item.data) * 16'(pos));

        hdr_ok_next = (pos == '0) ? (item.data == cfg.header_value) : hdr_ok_reg;
        good        = is_last && hdr_ok_next && (item.data == sum_base);

        count_next = count_reg;
        sum_next   = sum_reg;
        done_next  = done_reg;
        idle_next  = idle_reg;
        out_next   = '0;

        if (item.operation == OP_TICK) begin
            hdr_ok_next = hdr_ok_reg;
            if (idle_reg != IDLE_MAX) begin
                idle_next = idle_reg + IDLE_W'(1);
            end
            out_next.receive_done = done_reg;
        end else begin
            idle_next = '0;
            if (is_last) begin
                count_next = '0;
                sum_next   = sum_base;
            end else begin
                count_next = pos + POS_W'(1);
                sum_next   = sum_base + weighted;   // weight is zero at position 0
            end
            done_next             = done_pre || good;
            out_next.byte_valid   = 1'b1;
            out_next.byte_index   = pos;
            out_next.byte_data    = item.data;
            out_next.frame_end    = is_last;
            out_next.frame_good   = good;
            out_next.receive_done = done_pre || good;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            sum_reg       <= '0;
            hdr_ok_reg    <= 1'b0;
            idle_reg      <= IDLE_MAX;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (item_take) begin
                count_reg  <= count_next;
                sum_reg    <= sum_next;
                hdr_ok_reg <= hdr_ok_next;
                idle_reg   <= idle_next;
                done_reg   <= done_next;
            end
            if (item_take) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== hw/rtl/checksummed_frame_receiver_unit.sv =====
// Checksummed frame receiver.
// Input channel (s_valid/s_ready/s_data): one transaction per timer tick
// (operation 0) or per received byte (operation 1, byte in data).
// Result channel (m_valid/m_ready/m_data): exactly one transaction per
// input transaction, in order: byte position, byte, frame end, frame good
// (header and weighted-sum checksum both matched) and the receive-done flag.
// Configuration: cfg_wr_en/cfg_index/cfg_wr_data write gap_limit (index 0)
// or header_value (index 1); other indexes are ignored.
// Write only while the block is idle.
// Path: an accepted input transaction is registered in the input register,
// then passes the frame logic into the result register, which drives m_data.
// Throughput: one transaction per cycle while m_ready stays high; the state
// update uses compares, adds and a single 8x6 multiply.
// Stall: a held result keeps m_data stable; one more item can wait in the
// input register, after which s_ready drops until m_ready returns.
// Reset (aresetn low, synchronous): both stages empty, frame position and
// checksum cleared, idle counter saturated, registers back to 1000 and 0xAA.
module checksummed_frame_receiver_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  cfr_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output cfr_pkg::out_item_t             m_data,
    input  logic                           cfg_wr_en,
    input  logic [cfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfr_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import cfr_pkg::*;

    cfg_t     cfg;
    logic     item_valid;
    in_item_t item;
    logic     item_take;

    // register file for gap limit and header
    cfr_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // input register holds one waiting item; s_ready still follows the result side
    cfr_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // frame state, checks and result register
    cfr_frame_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== hw/rtl/cfr_checker.sv =====
`include "checksummed_frame_receiver_unit_macros.svh"

module cfr_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input cfr_pkg::out_item_t m_data
);
    import cfr_pkg::*;

    `CFR_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")
    `CFR_ASSERT_NOW(a_end_is_byte, aclk, aresetn, m_valid && m_data.frame_end, m_data.byte_valid && (m_data.byte_index == LAST_POS), "frame end off last position")
    `CFR_ASSERT_NOW(a_good_sets_done, aclk, aresetn, m_valid && m_data.frame_good, m_data.frame_end && m_data.receive_done, "good frame without done")
    `CFR_ASSERT_NOW(a_tick_clean, aclk, aresetn, m_valid && !m_data.byte_valid, (m_data.byte_index == '0) && (m_data.byte_data == '0) && !m_data.frame_end, "tick result carries byte fields")
    // an accepted input transaction must be followed by a valid result
    `CFR_ASSERT_NEXT(a_accept_result, aclk, aresetn, s_valid && s_ready, ##1 m_valid, "no result after accepted item")

endmodule

bind checksummed_frame_receiver_unit cfr_checker u_cfr_checker (.*);

// ===== sim/tb_checksummed_frame_receiver_unit.sv =====
`timescale 1ns / 1ps

module tb_checksummed_frame_receiver_unit;
    import cfr_pkg::*;

    // Items per random phase, settle time after the last result and the watchdog
    // limit in cycles without any transaction on either channel.
    localparam int PHASE_ITEMS    = 150;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SHOW_LIMIT     = 10;

    // Register indexes past the end of the list: writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

    // One line of stimulus. Where "typed" is set, "want" is the result read
    // straight off the behaviour and replaces the predicted one.
    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    // Typed expectation travelling with the item on s_data; updated by
    // nonblocking assignment together with s_data so the monitor sees the
    // value belonging to the accepted transaction.
    logic      cur_typed;
    out_item_t cur_want;

    checksummed_frame_receiver_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame receiver shadow: registers and frame state
    // ------------------------------------------------------------------
    logic [IDLE_W-1:0] gap_lim  = GAP_LIMIT_RST;
    logic [7:0]        hdr_val  = HEADER_VALUE_RST;
    logic [POS_W-1:0]  fr_count = '0;
    logic [7:0]        fr_sum   = '0;
    logic              fr_hdr_ok = 1'b0;
    logic [IDLE_W-1:0] fr_idle  = IDLE_MAX;
    logic              fr_done  = 1'b0;

    // Results still to come out of the receiver, oldest first.
    out_item_t rx_report_q[$];
    stim_row_t stim_q[$];

    int  fail_count = 0;
    int  quiet_cycles = 0;
    bit  calm = 1'b0;           // no idling on either side while set

    task automatic frame_rx_config(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_GAP_LIMIT)
            gap_lim = val;
        else if (idx == CFG_HEADER_VALUE)
            hdr_val = val[7:0];
    endtask

    // One input transaction in, one result out.
    task automatic frame_rx_step(input in_item_t it, output out_item_t res);
        logic [POS_W-1:0] pos;
        res = '0;
        if (it.operation == OP_TICK) begin
            // idle counter saturates; the flag is reported as it stands
            if (fr_idle != IDLE_MAX)
                fr_idle = fr_idle + 1'b1;
            res.receive_done = fr_done;
        end else begin
            // too long a silence: restart at byte 0 and drop the done flag
            if (fr_idle > gap_lim) begin
                fr_count = '0;
                fr_done  = 1'b0;
            end
            fr_idle = '0;
            pos = fr_count;
            if (pos >= FRAME_LENGTH)
                pos = '0;
            if (pos == '0) begin
                fr_hdr_ok = (it.data == hdr_val);
                fr_sum    = '0;
            end
            if (pos == LAST_POS) begin
                res.frame_end = 1'b1;
                if (fr_hdr_ok && it.data == fr_sum) begin
                    res.frame_good = 1'b1;
                    fr_done        = 1'b1;
                end
                fr_count = '0;
            end else begin
                // weighted sum over the payload bytes, mod 256
                if (pos != '0)
                    fr_sum = fr_sum + 8'(it.data * pos);
                fr_count = pos + 1'b1;
            end
            res.byte_valid   = 1'b1;
            res.byte_index   = pos;
            res.byte_data    = it.data;
            res.receive_done = fr_done;
        end
    endtask

    function automatic bit rx_item_differs(input out_item_t a, input out_item_t b);
        return (a.byte_valid   !== b.byte_valid)   ||
               (a.byte_index   !== b.byte_index)   ||
               (a.byte_data    !== b.byte_data)    ||
               (a.frame_end    !== b.frame_end)    ||
               (a.frame_good   !== b.frame_good)   ||
               (a.receive_done !== b.receive_done);
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predicts on input transactions, checks result transactions,
    // and runs the watchdog. Everything is sampled at the rising edge,
    // before any of this edge's nonblocking updates land.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t want;
        out_item_t pred;
        if (aresetn) begin
            // check first, so a stray result is never matched against an
            // expectation pushed at the same edge
            if (m_valid && m_ready) begin
                if (rx_report_q.size() == 0) begin
                    if (fail_count < SHOW_LIMIT)
                        $display("%0t: result with nothing pending: v=%0d idx=%0d d=%02h end=%0d good=%0d done=%0d",
                                 $realtime, m_data.byte_valid, m_data.byte_index,
                                 m_data.byte_data, m_data.frame_end,
                                 m_data.frame_good, m_data.receive_done);
                    fail_count++;
                end else begin
                    want = rx_report_q.pop_front();
                    if (rx_item_differs(want, m_data)) begin
                        if (fail_count < SHOW_LIMIT)
                            $display("%0t: mismatch want v=%0d idx=%0d d=%02h end=%0d good=%0d done=%0d | got v=%0d idx=%0d d=%02h end=%0d good=%0d done=%0d",
                                     $realtime, want.byte_valid, want.byte_index,
                                     want.byte_data, want.frame_end, want.frame_good,
                                     want.receive_done, m_data.byte_valid,
                                     m_data.byte_index, m_data.byte_data,
                                     m_data.frame_end, m_data.frame_good,
                                     m_data.receive_done);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                frame_rx_step(s_data, pred);
                rx_report_q.push_back(cur_typed ? cur_want : pred);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("[checksummed_frame_receiver_unit] ERROR");
                $finish;
            end
        end
    end

    // Result side back-pressure: random stalls, none while calm.
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_row(input logic op, input logic [7:0] d, input logic typed,
                            input out_item_t want);
        stim_row_t row;
        row.item  = in_item_t'{op, d};
        row.typed = typed;
        row.want  = want;
        stim_q.push_back(row);
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) push_row(OP_TICK, 8'($urandom), 1'b0, '0);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    // One frame, mostly well formed. Broken ones: wrong header, wrong
    // checksum, or cut short. A cut frame is only made where the gap limit is
    // small enough to realign cheaply, and is always followed by a restart.
    // Ticks inside a frame never exceed the gap limit, so the frame holds.
    task automatic queue_frame();
        int          kind;
        int          cut;
        int          p;
        int          r;
        int          lim;
        logic [7:0]  b;
        logic [7:0]  sum;
        lim  = int'(gap_lim);
        kind = $urandom_range(0, 99);
        cut  = FRAME_LENGTH;
        if (kind >= 90 && lim <= 40)
            cut = $urandom_range(1, FRAME_LENGTH - 1);
        sum = 8'h00;
        for (p = 0; p < cut; p++) begin
            if (p == 0)
                b = (kind >= 70 && kind < 80) ? 8'($urandom) : hdr_val;
            else if (p == FRAME_LENGTH - 1)
                b = (kind >= 80 && kind < 90) ? (sum ^ 8'($urandom_range(1, 255))) : sum;
            else begin
                b   = pick_byte();
                sum = sum + 8'(b * p);
            end
            push_row(OP_BYTE, b, 1'b0, '0);
            if (p != cut - 1) begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    ;
                else if (r < 95)
                    queue_ticks($urandom_range(0, (lim < 3) ? lim : 3));
                else if (lim <= 40)
                    queue_ticks(lim);       // right at the limit: no restart
                else
                    queue_ticks($urandom_range(0, 3));
            end
        end
        if (cut < FRAME_LENGTH)
            queue_ticks(lim + 1);           // one past the limit: restart
        else begin
            r = $urandom_range(0, 99);
            if (r < 60)
                ;
            else if (r < 90 || lim > 40)
                queue_ticks($urandom_range(1, 4));
            else
                queue_ticks(lim + 1);
        end
    endtask

    // Sends the queued stimulus. At item hold_at the sender stops and waits
    // for the receiver to catch up completely.
    task automatic send_stim(input int hold_at);
        int        n;
        int        gap;
        stim_row_t row;
        n = 0;
        while (stim_q.size() != 0) begin
            if (n == hold_at) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (rx_report_q.size() != 0);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            row = stim_q.pop_front();
            s_valid   <= 1'b1;
            s_data    <= row.item;
            cur_typed <= row.typed;
            cur_want  <= row.want;
            do @(posedge aclk); while (!s_ready);
            n++;
        end
        s_valid <= 1'b0;
    endtask

    // Wait until every result is in, then let the pipeline settle. The first
    // edge lets the monitor log the last accepted item before the queue is read.
    task automatic drain();
        @(posedge aclk);
        while (rx_report_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        frame_rx_config(idx, val);
        @(posedge aclk);
    endtask

    task automatic run_phase(input logic [IDLE_W-1:0] gap, input logic [7:0] hdr,
                             input bit quiet, input int hold_at);
        // upper bits of the header write are junk and must be ignored
        write_reg(CFG_GAP_LIMIT, gap);
        write_reg(CFG_HEADER_VALUE, {8'($urandom), hdr});
        write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                  CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
        calm = quiet;
        while (stim_q.size() < PHASE_ITEMS)
            queue_frame();
        send_stim(hold_at);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int p;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        cur_typed   = 1'b0;
        cur_want    = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frame at reset settings (gap 1000, header 0xAA).
        // Tick straight after reset: idle counter already saturated.
        push_row(OP_TICK, 8'h00, 1'b1, out_item_t'{1'b0, 6'd0, 8'h00, 1'b0, 1'b0, 1'b0});
        // first byte after reset: gap fires, taken at position 0
        push_row(OP_BYTE, 8'hAA, 1'b1, out_item_t'{1'b1, 6'd0, 8'hAA, 1'b0, 1'b0, 1'b0});
        push_row(OP_BYTE, 8'hFF, 1'b0, '0);
        push_row(OP_TICK, 8'h00, 1'b0, '0);          // short pause mid-frame
        for (p = 2; p < FRAME_LENGTH - 1; p++)
            push_row(OP_BYTE, 8'h00, 1'b0, '0);
        // checksum 0xFF * 1 = 0xFF: good frame, done flag set
        push_row(OP_BYTE, 8'hFF, 1'b1, out_item_t'{1'b1, LAST_POS, 8'hFF, 1'b1, 1'b1, 1'b1});
        push_row(OP_TICK, 8'h00, 1'b1, out_item_t'{1'b0, 6'd0, 8'h00, 1'b0, 1'b0, 1'b1});
        // data on a tick is ignored
        push_row(OP_TICK, 8'hFF, 1'b1, out_item_t'{1'b0, 6'd0, 8'h00, 1'b0, 1'b0, 1'b1});
        send_stim(-1);
        drain();

        // Random phases: defaults, both gap extremes, both header extremes,
        // and random settings. The second one holds the sender mid-way.
        run_phase(GAP_LIMIT_RST, HEADER_VALUE_RST, 1'b0, -1);
        run_phase(16'd0, 8'h00, 1'b0, PHASE_ITEMS / 2);
        run_phase(16'hFFFF, 8'hFF, 1'b1, -1);
        run_phase(16'd3, 8'h5A, 1'b0, -1);
        run_phase(IDLE_W'($urandom_range(1, 40)), 8'($urandom), 1'b0, -1);
        run_phase(IDLE_W'($urandom), 8'($urandom), 1'b0, -1);

        if (fail_count == 0)
            $display("[checksummed_frame_receiver_unit] OK");
        else
            $display("[checksummed_frame_receiver_unit] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_cfg_regs.sv
hw/rtl/cfr_in_reg.sv
hw/rtl/cfr_frame_core.sv
hw/rtl/checksummed_frame_receiver_unit.sv
hw/rtl/cfr_checker.sv
sim/tb_checksummed_frame_receiver_unit.sv
